@@ hdl/decimated_angle_velocity_observer_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DECIMATED_ANGLE_VELOCITY_OBSERVER_CORE_MACROS_SVH
`define DECIMATED_ANGLE_VELOCITY_OBSERVER_CORE_MACROS_SVH

// same-cycle implication
`define DAVO_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DAVO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/davo_pkg.sv @@
// ----------------------------------------------------------------------------
// davo_pkg
// Types and constants of the decimated angle velocity observer.
// ----------------------------------------------------------------------------
package davo_pkg;

    localparam int ANGLE_W    = 32;
    localparam int LEVEL_W    = 7;
    localparam int RATIO_W    = 7;
    localparam int RATE_W     = 20;
    localparam int DCNT_W     = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam int DIFF_W     = ANGLE_W + 1;
    localparam int PROD_W     = 52;
    localparam int DIV_BITS   = 4;
    localparam int DIV_CYCLES = ANGLE_W / DIV_BITS;
    localparam int DIVCNT_W   = $clog2(DIV_CYCLES);
    localparam int LEVEL_MAX  = 126;

    localparam logic [RATIO_W-1:0] RATIO_MAX   = 7'd64;
    localparam logic [RATIO_W-1:0] RATIO_RESET = 7'd1;
    localparam logic [RATE_W-1:0]  RATE_RESET  = 20'd10000;

    localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_LEVEL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OVERSAMPLE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE     = 2'd2;

    localparam logic [ANGLE_W-1:0] VEL_MAX = 32'h7FFF_FFFF;
    localparam logic [ANGLE_W-1:0] VEL_MIN = 32'h8000_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_MUL,
        ST_DINIT,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic diff;
        logic mul;
        logic div_init;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic keep;
        logic div_last;
        logic out_full;
    } status_t;

endpackage

@@ hdl/davo_ctrl.sv @@
// ----------------------------------------------------------------------------
// davo_ctrl
// Sequencer: accept, history read, difference, multiply, divide, output.
// ----------------------------------------------------------------------------
`include "decimated_angle_velocity_observer_core_macros.svh"

module davo_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  davo_pkg::status_t status,
    output davo_pkg::cmd_t    cmd
);
    import davo_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && status.keep)
                begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:  state_next = ST_MUL;
            ST_MUL:   state_next = ST_DINIT;
            ST_DINIT: state_next = ST_DIV;
            ST_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!status.out_full)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_DIFF:  cmd.diff     = 1'b1;
            ST_MUL:   cmd.mul      = 1'b1;
            ST_DINIT: cmd.div_init = 1'b1;
            ST_DIV:   cmd.div_step = 1'b1;
            ST_DONE:  cmd.out_load = !status.out_full;
            default:  cmd          = '0;
        endcase
    end

    `DAVO_ASSERT_NEXT(a_div_to_done, (state_reg == ST_DIV) && status.div_last, state_reg == ST_DONE, "divide did not finish")
    `DAVO_ASSERT_NEXT(a_drop_stays_idle, s_tvalid && s_tready && !status.keep, state_reg == ST_IDLE, "dropped sample started work")
    `DAVO_ASSERT_NOW(a_load_only_idle, cmd.load, s_tready, "load outside accept")

endmodule

@@ hdl/davo_datapath.sv @@
// ----------------------------------------------------------------------------
// davo_datapath
// Config registers, decimator, angle history, multiplier, divider, output.
// ----------------------------------------------------------------------------
`include "decimated_angle_velocity_observer_core_macros.svh"

module davo_datapath #(
    parameter int HISTORY_DEPTH = 128
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [davo_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [davo_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [davo_pkg::ANGLE_W-1:0]        s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [2*davo_pkg::ANGLE_W-1:0]      m_tdata,
    input  davo_pkg::cmd_t                      cmd,
    output davo_pkg::status_t                   status
);
    import davo_pkg::*;

    localparam int ADDR_W    = $clog2(HISTORY_DEPTH);
    localparam int CNT_W     = $clog2(HISTORY_DEPTH + 1);
    localparam int CALC_W    = (ADDR_W > LEVEL_W) ? ADDR_W + 1 : LEVEL_W + 1;
    localparam int LEVEL_CAP = (HISTORY_DEPTH - 2 < LEVEL_MAX) ? HISTORY_DEPTH - 2 : LEVEL_MAX;

    // configuration
    logic [LEVEL_W-1:0] level_reg;
    logic [RATIO_W-1:0] ratio_reg;
    logic [RATE_W-1:0]  rate_reg;
    logic [RATIO_W-1:0] cfg_low7;

    assign cfg_low7 = cfg_data[RATIO_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
            ratio_reg <= RATIO_RESET;
            rate_reg  <= RATE_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_VELOCITY_LEVEL:
                begin
                    level_reg <= (cfg_low7 > LEVEL_W'(LEVEL_CAP)) ? LEVEL_W'(LEVEL_CAP)
                                                                  : cfg_low7;
                end
                REG_OVERSAMPLE:
                begin
                    if (cfg_low7 == '0)
                    begin
                        ratio_reg <= RATIO_W'(1);
                    end
                    else if (cfg_low7 > RATIO_MAX)
                    begin
                        ratio_reg <= RATIO_MAX;
                    end
                    else
                    begin
                        ratio_reg <= cfg_low7;
                    end
                end
                REG_SAMPLE_RATE: rate_reg <= cfg_data[RATE_W-1:0];
                default: ;
            endcase
        end
    end

    // decimation and history addressing
    logic [DCNT_W-1:0]  dcnt_reg;
    logic [RATIO_W-1:0] dcnt_inc;
    logic               keep;
    logic [ADDR_W-1:0]  wp_reg;
    logic [ADDR_W-1:0]  wp_next;
    logic [CNT_W-1:0]   fill_reg;
    logic [LEVEL_W-1:0] span;
    logic [CALC_W-1:0]  wp_ext;
    logic [CALC_W-1:0]  span_ext;
    logic [CALC_W-1:0]  older_ext;
    logic [ADDR_W-1:0]  older;
    logic               store;

    assign dcnt_inc  = RATIO_W'(dcnt_reg) + RATIO_W'(1);
    assign keep      = dcnt_inc >= ratio_reg;
    assign store     = cmd.load && keep;
    assign wp_next   = (wp_reg == ADDR_W'(HISTORY_DEPTH - 1)) ? '0 : wp_reg + ADDR_W'(1);
    assign span      = level_reg + LEVEL_W'(1);
    assign wp_ext    = CALC_W'(wp_next);
    assign span_ext  = CALC_W'(span);
    assign older_ext = (wp_ext >= span_ext) ? wp_ext - span_ext
                                            : wp_ext + CALC_W'(HISTORY_DEPTH) - span_ext;
    assign older     = older_ext[ADDR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg <= '0;
            wp_reg   <= ADDR_W'(HISTORY_DEPTH - 1);
            fill_reg <= '0;
        end
        else if (cmd.load)
        begin
            dcnt_reg <= keep ? '0 : dcnt_inc[DCNT_W-1:0];
            if (keep)
            begin
                wp_reg <= wp_next;
                if (fill_reg != CNT_W'(HISTORY_DEPTH))
                begin
                    fill_reg <= fill_reg + CNT_W'(1);
                end
            end
        end
    end

    // history memory: one write and one read per stored word
    logic [ANGLE_W-1:0] hist_mem [HISTORY_DEPTH];
    logic [ANGLE_W-1:0] rd_reg;
    logic [ANGLE_W-1:0] angle_reg;
    logic               older_valid_reg;

    always_ff @(posedge clk)
    begin
        if (store)
        begin
            hist_mem[wp_next] <= s_tdata;
            rd_reg            <= hist_mem[older];
            angle_reg         <= s_tdata;
            older_valid_reg   <= CNT_W'(older) < fill_reg;
        end
    end

    // difference and product
    logic [ANGLE_W-1:0]  base;
    logic [DIFF_W-1:0]   diff;
    logic [DIFF_W-1:0]   mag_reg;
    logic                neg_reg;
    logic [PROD_W-1:0]   prod_full;
    logic [PROD_W-1:0]   prod_reg;

    assign base      = older_valid_reg ? rd_reg : '0;
    assign diff      = {angle_reg[ANGLE_W-1], angle_reg} - {base[ANGLE_W-1], base};
    assign prod_full = PROD_W'(mag_reg) * PROD_W'(rate_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.diff)
        begin
            neg_reg <= diff[DIFF_W-1];
            mag_reg <= diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_full;
        end
    end

    // divider, DIV_BITS quotient bits per cycle
    logic [LEVEL_W-1:0]  rem_reg;
    logic [ANGLE_W-1:0]  quo_reg;
    logic                ovf_reg;
    logic [DIVCNT_W-1:0] divcnt_reg;
    logic [LEVEL_W-1:0]  rem_step;
    logic [ANGLE_W-1:0]  quo_step;

    always_comb
    begin
        logic [LEVEL_W:0] trial;
        rem_step = rem_reg;
        quo_step = quo_reg;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            trial    = {rem_step, quo_step[ANGLE_W-1]};
            quo_step = {quo_step[ANGLE_W-2:0], 1'b0};
            if (trial >= {1'b0, span})
            begin
                trial       = trial - {1'b0, span};
                quo_step[0] = 1'b1;
            end
            rem_step = trial[LEVEL_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            ovf_reg <= prod_reg[PROD_W-1:ANGLE_W] >= (PROD_W - ANGLE_W)'(span);
            rem_reg <= prod_reg[ANGLE_W+LEVEL_W-1:ANGLE_W];
            quo_reg <= prod_reg[ANGLE_W-1:0];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_step;
            quo_reg <= quo_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divcnt_reg <= '0;
        end
        else if (cmd.div_init)
        begin
            divcnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            divcnt_reg <= divcnt_reg + DIVCNT_W'(1);
        end
    end

    // saturation and output register
    logic [ANGLE_W-1:0] vel;
    logic [ANGLE_W-1:0] angle_out_reg;
    logic [ANGLE_W-1:0] vel_out_reg;
    logic               out_valid_reg;

    always_comb
    begin
        if (ovf_reg)
        begin
            vel = neg_reg ? VEL_MIN : VEL_MAX;
        end
        else if (neg_reg)
        begin
            vel = (quo_reg > VEL_MIN) ? VEL_MIN : (~quo_reg + ANGLE_W'(1));
        end
        else
        begin
            vel = quo_reg[ANGLE_W-1] ? VEL_MAX : quo_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            angle_out_reg <= angle_reg;
            vel_out_reg   <= vel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = {vel_out_reg, angle_out_reg};
    assign status.keep     = keep;
    assign status.div_last = divcnt_reg == DIVCNT_W'(DIV_CYCLES - 1);
    assign status.out_full = out_valid_reg;

    `DAVO_ASSERT_NOW(a_older_not_new, store, older != wp_next, "history read hits write slot")
    `DAVO_ASSERT_NOW(a_rem_below_span, cmd.div_step && !ovf_reg, rem_reg < span, "bad remainder")
    `DAVO_ASSERT_NOW(a_no_overwrite, cmd.out_load, !out_valid_reg, "output word overwritten")
    `DAVO_ASSERT_NOW(a_ratio_range, 1'b1, ratio_reg != '0 && ratio_reg <= RATIO_MAX, "bad ratio")

endmodule

@@ hdl/decimated_angle_velocity_observer_core.sv @@
// ----------------------------------------------------------------------------
// decimated_angle_velocity_observer_core
// Keeps every Nth angle sample in a circular history and outputs the angle
// with a finite-difference velocity, scaled by the sample rate, saturated.
// ----------------------------------------------------------------------------
//  channel   dir  word
//  s_*       in   tdata[31:0] sample_angle
//  m_*       out  tdata[31:0] angle_out, [63:32] velocity_out
//  cfg_*     in   cfg_index register, cfg_data value (always ready)
//
//  Dropped sample: the sequencer stays idle. Kept sample: history read,
//  difference, multiply, divider load, 8 divide steps of 4 bits each, and
//  output load, which makes the output word valid; the next sample follows.
//  Reset clears control state; history entries not yet written read as zero.
//  A finished word waits in the output register; the next sample is taken
//  meanwhile, and a kept one stalls only at its own output load.
// ----------------------------------------------------------------------------
module decimated_angle_velocity_observer_core #(
    parameter int HISTORY_DEPTH = 128
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [davo_pkg::ANGLE_W-1:0]    s_tdata,    // [31:0] sample_angle
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [2*davo_pkg::ANGLE_W-1:0]  m_tdata,    // [31:0] angle_out, [63:32] velocity_out
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [davo_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [davo_pkg::CFG_DATA_W-1:0] cfg_data
);
    import davo_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    davo_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    davo_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the decimated angle velocity observer: streams
// angle words through a randomly stalled handshake and compares every output
// word against a bit-true observer model kept alongside the stimulus.
// ----------------------------------------------------------------------------
module tb_top;

    import davo_pkg::*;

    localparam int HIST_DEPTH = 128;
    localparam int ITEM_TARGET = 1100;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic [ANGLE_W-1:0] velocity;
    } obs_word_t;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [ANGLE_W-1:0]     s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [2*ANGLE_W-1:0]   m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // observer model state
    logic signed [ANGLE_W-1:0] hist [0:HIST_DEPTH-1];
    int                        wr_pos;
    int                        dec_count;
    int                        level_reg;
    int                        ratio_reg;
    int unsigned               rate_reg;

    logic [ANGLE_W-1:0] raw_angles [$];
    obs_word_t          predicted_words [$];
    int unsigned        items_sent;
    int unsigned        items_taken;
    int unsigned        words_seen;
    int unsigned        mismatches;
    bit                 tx_calm;
    bit                 rx_calm;
    int unsigned        gap_left;
    int unsigned        stall_left;
    int unsigned        hold_left;
    bit                 hold_done;

    decimated_angle_velocity_observer_core #(
        .HISTORY_DEPTH(HIST_DEPTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void clear_observer();
        for (int i = 0; i < HIST_DEPTH; i++)
        begin
            hist[i] = '0;
        end
        wr_pos    = HIST_DEPTH - 1;
        dec_count = 0;
        level_reg = 0;
        ratio_reg = int'(RATIO_RESET);
        rate_reg  = 32'(RATE_RESET);
    endfunction

    // decimate, store, and predict the output word for a kept sample
    function automatic void track_sample(input logic [ANGLE_W-1:0] sample);
        longint    diff;
        longint    prod;
        longint    quo;
        longint    span;
        int        older;
        obs_word_t w;
        if (dec_count + 1 >= ratio_reg)
            dec_count = 0;
        else
            dec_count = (dec_count + 1) & 63;
        if (dec_count != 0)
            return;
        wr_pos = (wr_pos + 1) % HIST_DEPTH;
        hist[wr_pos] = sample;
        span  = longint'(level_reg + 1);
        older = (wr_pos + HIST_DEPTH - int'(span)) % HIST_DEPTH;
        diff  = longint'(hist[wr_pos]) - longint'(hist[older]);
        prod  = diff * longint'(rate_reg);
        quo   = prod / span;
        if (quo > 64'sd2147483647)
            w.velocity = VEL_MAX;
        else if (quo < -64'sd2147483648)
            w.velocity = VEL_MIN;
        else
            w.velocity = quo[ANGLE_W-1:0];
        w.angle = sample;
        predicted_words.push_back(w);
    endfunction

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            gap_left = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                track_sample(s_tdata);
                items_taken++;
            end
            if (!(s_tvalid && !s_tready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (raw_angles.size() != 0)
                begin
                    s_tdata  <= raw_angles.pop_front();
                    s_tvalid <= 1'b1;
                    gap_left = tx_calm ? 0 : $urandom_range(0, 9);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // output monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                words_seen++;
                if (predicted_words.size() == 0)
                begin
                    $display("%0t: unexpected word: expected none actual %h", $time, m_tdata);
                    mismatches++;
                end
                else
                begin
                    obs_word_t w;
                    w = predicted_words.pop_front();
                    if (m_tdata[ANGLE_W-1:0] !== w.angle)
                    begin
                        $display("%0t: angle_out: expected %h actual %h",
                                 $time, w.angle, m_tdata[ANGLE_W-1:0]);
                        mismatches++;
                    end
                    if (m_tdata[2*ANGLE_W-1:ANGLE_W] !== w.velocity)
                    begin
                        $display("%0t: velocity_out: expected %h actual %h",
                                 $time, w.velocity, m_tdata[2*ANGLE_W-1:ANGLE_W]);
                        mismatches++;
                    end
                end
                stall_left = rx_calm ? 0 : $urandom_range(0, 9);
            end
            // long back-pressure stretch to fill the block
            if (!hold_done && words_seen == 150)
            begin
                hold_done = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic queue_angle(input logic [ANGLE_W-1:0] a);
        raw_angles.push_back(a);
        items_sent++;
    endtask

    task automatic drain();
        while (items_taken != items_sent || predicted_words.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        logic [6:0] low7;
        low7 = val[6:0];
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_VELOCITY_LEVEL: level_reg = (low7 > LEVEL_MAX) ? LEVEL_MAX : int'(low7);
            REG_OVERSAMPLE:     ratio_reg = (low7 == 0) ? 1 :
                                            ((low7 > RATIO_MAX) ? int'(RATIO_MAX) : int'(low7));
            REG_SAMPLE_RATE:    rate_reg  = 32'(val);
            default: ;
        endcase
        @(posedge clk);
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] lvl_w;
        logic [CFG_DATA_W-1:0] ratio_w;
        logic [CFG_DATA_W-1:0] rate_w;
        logic [ANGLE_W-1:0]    ramp;
        int                    amp;
        int                    mode;
        int                    len;
        clear_observer();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: extremes, early samples, saturation
        queue_angle(32'h7FFF_FFFF);
        queue_angle(32'h8000_0000);
        queue_angle(32'h0000_0000);
        queue_angle(32'hFFFF_FFFF);
        queue_angle(32'h5555_5555);
        queue_angle(32'hAAAA_AAAA);
        drain();
        // level above cap, ratio zero with upper bits set, full-scale rate
        write_reg(REG_VELOCITY_LEVEL, 20'hFFFFF);
        write_reg(REG_OVERSAMPLE, 20'hFFF80);
        write_reg(REG_SAMPLE_RATE, 20'hFFFFF);
        queue_angle(32'h7FFF_FFFF);
        queue_angle(32'h8000_0000);
        drain();
        write_reg(REG_SAMPLE_RATE, 20'd0);
        queue_angle(32'h1234_5678);
        drain();
        // ratio lowered while a count is in progress
        write_reg(REG_VELOCITY_LEVEL, 20'd0);
        write_reg(REG_SAMPLE_RATE, 20'd1);
        write_reg(REG_OVERSAMPLE, 20'd5);
        queue_angle(32'h0001_0000);
        queue_angle(32'h0002_0000);
        queue_angle(32'h0003_0000);
        drain();
        write_reg(REG_OVERSAMPLE, 20'd2);
        queue_angle(32'hFFFE_0000);
        queue_angle(32'h0004_0000);
        drain();
        write_reg(REG_OVERSAMPLE, 20'd100);
        queue_angle(32'h0005_0000);
        queue_angle(32'h0006_0000);
        drain();

        // random phases
        ramp = $urandom;
        while (items_sent < ITEM_TARGET)
        begin
            case ($urandom_range(0, 5))
                0:       lvl_w = 20'd0;
                1:       lvl_w = 20'd126;
                2:       lvl_w = {13'($urandom_range(0, 8191)), 7'h7F};
                3:       lvl_w = CFG_DATA_W'($urandom_range(0, 127));
                default: lvl_w = CFG_DATA_W'($urandom_range(0, 8));
            endcase
            case ($urandom_range(0, 9))
                0:       ratio_w = 20'd64;
                1:       ratio_w = {13'($urandom_range(0, 8191)), 7'h00};
                2:       ratio_w = CFG_DATA_W'($urandom_range(65, 127));
                3:       ratio_w = CFG_DATA_W'($urandom_range(5, 64));
                default: ratio_w = CFG_DATA_W'($urandom_range(1, 3));
            endcase
            case ($urandom_range(0, 7))
                0:       rate_w = 20'd0;
                1:       rate_w = 20'd1;
                2:       rate_w = 20'hFFFFF;
                3:       rate_w = 20'd1000000;
                4:       rate_w = CFG_DATA_W'($urandom);
                default: rate_w = CFG_DATA_W'($urandom_range(1, 50000));
            endcase
            write_reg(REG_SAMPLE_RATE, rate_w);
            write_reg(REG_VELOCITY_LEVEL, lvl_w);
            write_reg(REG_OVERSAMPLE, ratio_w);
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            if (ratio_reg > 4)
                len = ratio_reg * int'($urandom_range(3, 6));
            else
                len = int'($urandom_range(20, 80));
            if (len > 400)
                len = 400;
            if (len > ITEM_TARGET - int'(items_sent))
                len = ITEM_TARGET - int'(items_sent);
            mode = int'($urandom_range(0, 9));
            amp  = 1 << $urandom_range(4, 20);
            for (int i = 0; i < len; i++)
            begin
                if (mode < 5)
                begin
                    ramp = ramp + ANGLE_W'($urandom_range(0, 2 * amp) - amp);
                    queue_angle(ramp);
                end
                else if (mode < 8)
                begin
                    queue_angle($urandom);
                end
                else
                begin
                    case ($urandom_range(0, 4))
                        0:       queue_angle(32'h7FFF_FFFF);
                        1:       queue_angle(32'h8000_0000);
                        2:       queue_angle(32'h0000_0000);
                        3:       queue_angle(32'hFFFF_FFFF);
                        default: queue_angle($urandom);
                    endcase
                end
            end
            drain();
        end

        while (items_taken != items_sent || predicted_words.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (mismatches == 0 && predicted_words.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
